/* src/ipv4hp_pkg.sv */
`timescale 1ns / 1ps

package ipv4hp_pkg;

    // Fixed part of the IPv4 header
    localparam int FIXED_HEADER_BYTES = 20;
    localparam int HDR_IDX_W          = $clog2(FIXED_HEADER_BYTES);

    // Header byte offsets
    localparam int OFS_VER_IHL  = 0;
    localparam int OFS_TLEN_HI  = 2;
    localparam int OFS_TLEN_LO  = 3;
    localparam int OFS_TTL      = 8;
    localparam int OFS_PROTO    = 9;
    localparam int OFS_CSUM_HI  = 10;
    localparam int OFS_CSUM_LO  = 11;
    localparam int OFS_SRC      = 12;
    localparam int OFS_DST      = 16;

    // Byte counts saturate here
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Protocol numbers of interest
    localparam logic [7:0] PNUM_ICMP = 8'd1;
    localparam logic [7:0] PNUM_IPIP = 8'd4;
    localparam logic [7:0] PNUM_TCP  = 8'd6;
    localparam logic [7:0] PNUM_UDP  = 8'd17;
    localparam logic [7:0] PNUM_IPV6 = 8'd41;
    localparam logic [7:0] PNUM_MPLS = 8'd137;

    // Next-protocol class codes
    localparam logic [2:0] CLS_PAYLOAD = 3'd0;
    localparam logic [2:0] CLS_TCP     = 3'd1;
    localparam logic [2:0] CLS_UDP     = 3'd2;
    localparam logic [2:0] CLS_ICMP    = 3'd3;
    localparam logic [2:0] CLS_IPIP    = 3'd4;
    localparam logic [2:0] CLS_IPV6    = 3'd5;
    localparam logic [2:0] CLS_MPLS    = 3'd6;
    localparam logic [2:0] CLS_NONE    = 3'd7;

    // Packed result width on the output stream
    localparam int RESULT_W = 145;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Packet accumulation state handed to the result stage
    typedef struct packed {
        logic                                fin;
        logic [15:0]                         count;
        logic [16:0]                         sum;
        logic [FIXED_HEADER_BYTES-1:0][7:0]  hdr;
    } t_acc_state;

    // One result, last field in the lowest bits
    typedef struct packed {
        logic [7:0]  time_to_live;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic [7:0]  protocol_number;
        logic [15:0] trimmed_size;
        logic [15:0] layer_size;
        logic [5:0]  options_length;
        logic [15:0] total_length;
        logic [5:0]  header_bytes;
        logic [2:0]  next_proto_class;
        logic        lengths_valid;
        logic        checksum_good;
    } t_result;

    // Output queue status
    typedef struct packed {
        logic out_vld;
        logic skd_vld;
    } t_q_stat;

    function automatic logic [2:0] proto_class(input logic [7:0] p);
        logic [2:0] c;
        case (p)
            PNUM_TCP:  c = CLS_TCP;
            PNUM_UDP:  c = CLS_UDP;
            PNUM_ICMP: c = CLS_ICMP;
            PNUM_IPIP: c = CLS_IPIP;
            PNUM_IPV6: c = CLS_IPV6;
            PNUM_MPLS: c = CLS_MPLS;
            default:   c = CLS_PAYLOAD;
        endcase
        return c;
    endfunction

endpackage

/* src/ipv4hp_accum.sv */
`timescale 1ns / 1ps

module ipv4hp_accum
    import ipv4hp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,     // byte request accepted
    input  logic       i_hold,    // finished packet waits for queue room
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_acc_state o_st
);

    logic [FIXED_HEADER_BYTES-1:0][7:0] r_hdr, n_hdr;
    logic [15:0]                        r_count, n_count;
    logic [16:0]                        r_sum, n_sum;
    logic                               r_fin, n_fin;

    logic [15:0] base_count;
    logic [16:0] base_sum;
    logic [17:0] sum_add;
    logic [15:0] addend;

    // Start from a cleared packet right after a result was taken
    assign base_count = r_fin ? 16'd0 : r_count;
    assign base_sum   = r_fin ? 17'd0 : r_sum;

    // Place the byte in its half of the 16-bit word
    assign addend  = base_count[0] ? {8'd0, i_byte} : {i_byte, 8'd0};
    assign sum_add = {1'b0, base_sum} + {2'b0, addend};

    always_comb begin
        n_hdr   = r_fin ? '0 : r_hdr;
        n_count = base_count;
        n_sum   = base_sum;
        n_fin   = 1'b0;
        if (i_hold) begin
            // Hold the finished packet until the queue takes it
            n_hdr   = r_hdr;
            n_count = r_count;
            n_sum   = r_sum;
            n_fin   = r_fin;
        end else if (i_acc) begin
            // Capture fixed header bytes and fold all but the checksum bytes into the sum
            if (base_count < 16'(FIXED_HEADER_BYTES)) begin
                n_hdr[base_count[HDR_IDX_W-1:0]] = i_byte;
                if (base_count != 16'(OFS_CSUM_HI) && base_count != 16'(OFS_CSUM_LO)) begin
                    n_sum = {1'b0, sum_add[15:0]} + {15'd0, sum_add[17:16]};
                end
            end
            if (base_count != COUNT_MAX) begin
                n_count = base_count + 16'd1;
            end
            n_fin = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_hdr   <= n_hdr;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_fin   <= n_fin;
        end
    end

    assign o_st = '{fin: r_fin, count: r_count, sum: r_sum, hdr: r_hdr};

endmodule

/* src/ipv4hp_result.sv */
`timescale 1ns / 1ps

module ipv4hp_result
    import ipv4hp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_acc_state i_st,
    input  logic       i_chk_en,
    input  logic       i_ready,   // downstream takes the request
    output t_result    o_res,
    output t_q_stat    o_q
);

    t_result     res;
    logic [15:0] cap;
    logic [15:0] tl;
    logic [15:0] csum;
    logic [16:0] fold;
    logic [5:0]  hl;
    logic [5:0]  opts;
    logic        full;
    logic        valid;

    t_result r_out, r_skd;
    logic    r_out_vld, r_skd_vld;
    logic    push, pop;

    // Evaluate the finished packet
    assign cap  = i_st.count;
    assign full = cap >= 16'(FIXED_HEADER_BYTES);
    assign hl   = {i_st.hdr[OFS_VER_IHL][3:0], 2'b00};
    assign tl   = {i_st.hdr[OFS_TLEN_HI], i_st.hdr[OFS_TLEN_LO]};
    assign csum = {i_st.hdr[OFS_CSUM_HI], i_st.hdr[OFS_CSUM_LO]};
    assign fold = {1'b0, i_st.sum[15:0]} + {16'd0, i_st.sum[16]};

    assign valid = full && (hl >= 6'(FIXED_HEADER_BYTES)) && ({10'd0, hl} <= tl);

    always_comb begin
        // Keep options only when the whole header was captured
        opts = 6'd0;
        if (valid && hl > 6'(FIXED_HEADER_BYTES) && cap >= {10'd0, hl}) begin
            opts = hl - 6'(FIXED_HEADER_BYTES);
        end

        res.checksum_good    = i_chk_en && full && (~fold[15:0] == csum);
        res.lengths_valid    = valid;
        res.header_bytes     = hl;
        res.total_length     = tl;
        res.options_length   = opts;
        res.protocol_number  = i_st.hdr[OFS_PROTO];
        res.time_to_live     = i_st.hdr[OFS_TTL];
        res.source_address   = {i_st.hdr[OFS_SRC], i_st.hdr[OFS_SRC+1],
                                i_st.hdr[OFS_SRC+2], i_st.hdr[OFS_SRC+3]};
        res.dest_address     = {i_st.hdr[OFS_DST], i_st.hdr[OFS_DST+1],
                                i_st.hdr[OFS_DST+2], i_st.hdr[OFS_DST+3]};
        if (valid) begin
            res.next_proto_class = proto_class(i_st.hdr[OFS_PROTO]);
            res.layer_size       = 16'(FIXED_HEADER_BYTES) + {10'd0, opts};
            res.trimmed_size     = (cap > tl) ? tl : cap;
        end else begin
            res.next_proto_class = CLS_NONE;
            res.layer_size       = cap;
            res.trimmed_size     = cap;
        end
    end

    // Two-entry output queue: output register plus skid register
    assign pop  = r_out_vld && i_ready;
    assign push = i_st.fin && !r_skd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (!r_out_vld || pop) begin
            r_out_vld <= r_skd_vld || push;
            r_skd_vld <= 1'b0;
        end else if (push) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || pop) begin
            r_out <= r_skd_vld ? r_skd : res;
        end else if (push) begin
            r_skd <= res;
        end
    end

    assign o_res = r_out;
    assign o_q   = '{out_vld: r_out_vld, skd_vld: r_skd_vld};

endmodule

/* src/ipv4_header_parser.sv */
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Contents
// --------  ---  -------------------------------  ------------------------------------
// s stream  in   i_s_tvalid/o_s_tready/i_s_tdata  packet byte [7:0]
//                i_s_tlast                        last captured byte of the packet
// m stream  out  o_m_tvalid/i_m_tready/o_m_tdata  one result per packet (see o_m_tdata)
// config    in   i_cfg_we/i_cfg_wdata             checksum check enable
//
// One byte is taken per cycle while o_s_tready is high. A result is valid on o_m_tdata once
// the accumulator has registered the packet as finished on accepting its last byte, and
// the output queue has then registered the result.
// Reset (synchronous, active low) clears the packet state and sets checksum
// checking on. A two-entry output queue absorbs downstream stalls; a finished packet
// that finds both entries full holds in the accumulator and o_s_tready drops until room opens.

module ipv4_header_parser
    import ipv4hp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [7:0] data_byte
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [0] checksum_good, [1] lengths_valid, [4:2] next_proto_class,
    // [10:5] header_bytes, [26:11] total_length, [32:27] options_length,
    // [48:33] layer_size, [64:49] trimmed_size, [72:65] protocol_number,
    // [104:73] source_address, [136:105] dest_address, [144:137] time_to_live,
    // [151:145] zero
    output logic [M_DATA_W-1:0] o_m_tdata,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    t_acc_state st;
    t_result    res;
    t_q_stat    q;
    logic       r_chk_en;
    logic       s_acc;
    logic       acc_hold;

    // Checksum check enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_chk_en <= i_cfg_wdata;
        end
    end

    // Hold input while a result waits on a full queue
    assign acc_hold   = st.fin && q.skd_vld;
    assign o_s_tready = !acc_hold;
    assign s_acc      = i_s_tvalid && o_s_tready;

    ipv4hp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (s_acc),
        .i_hold  (acc_hold),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_st    (st)
    );

    ipv4hp_result u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_st     (st),
        .i_chk_en (r_chk_en),
        .i_ready  (i_m_tready),
        .o_res    (res),
        .o_q      (q)
    );

    assign o_m_tvalid = q.out_vld;
    assign o_m_tdata  = {(M_DATA_W - RESULT_W)'(0), res};

    // A last byte always leaves a finished packet behind
    a_last_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tlast |=> st.fin)
        else $error("last byte did not finish the packet");

    // A finished packet with queue room reaches the output
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.fin && !q.skd_vld |=> o_m_tvalid)
        else $error("finished packet not queued");

    // Skid entry only exists behind an occupied output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q.skd_vld |-> q.out_vld)
        else $error("skid register valid with empty output register");

    // Well-formed results carry a full fixed header length and a protocol class
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res.lengths_valid |->
            res.header_bytes >= 6'(FIXED_HEADER_BYTES) &&
            res.next_proto_class != CLS_NONE)
        else $error("valid lengths with short header or no class");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import ipv4hp_pkg::*;
;

    localparam int CLK_PERIOD     = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 650;
    localparam int MIN_PACKETS    = 20;
    localparam int PHASE_PACKETS  = 6;

    // Expected packet summaries, predicted from the accepted bytes
    class header_scoreboard;
        logic [7:0]  hdr_bytes [FIXED_HEADER_BYTES];
        logic [15:0] seen_count;
        logic [16:0] run_sum;
        bit          csum_on;
        t_result     expected_summaries[$];
        int          errors;
        int          checked;

        function new();
            clear_packet();
            csum_on = 1'b1;
            errors  = 0;
            checked = 0;
        endfunction

        function void clear_packet();
            foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
            seen_count = '0;
            run_sum    = '0;
        endfunction

        function void set_csum_check(bit on);
            csum_on = on;
        endfunction

        function int pending();
            return expected_summaries.size();
        endfunction

        // Build the summary of the packet held so far
        function t_result summarize_packet();
            t_result     r;
            logic [16:0] s;
            logic [15:0] cap;
            logic [15:0] tl;
            logic [15:0] stored;
            logic [5:0]  hl;
            logic [5:0]  opts;
            bit          full;
            bit          valid;
            r    = '0;
            cap  = seen_count;
            full = cap >= FIXED_HEADER_BYTES;
            hl   = {hdr_bytes[OFS_VER_IHL][3:0], 2'b00};
            tl   = {hdr_bytes[OFS_TLEN_HI], hdr_bytes[OFS_TLEN_LO]};
            if (csum_on && full) begin
                s      = {1'b0, run_sum[15:0]} + {16'd0, run_sum[16]};
                stored = {hdr_bytes[OFS_CSUM_HI], hdr_bytes[OFS_CSUM_LO]};
                r.checksum_good = (~s[15:0] == stored);
            end
            valid = full && hl >= FIXED_HEADER_BYTES && hl <= tl;
            r.lengths_valid = valid;
            r.header_bytes  = hl;
            r.total_length  = tl;
            if (valid) begin
                case (hdr_bytes[OFS_PROTO])
                    PNUM_TCP:  r.next_proto_class = CLS_TCP;
                    PNUM_UDP:  r.next_proto_class = CLS_UDP;
                    PNUM_ICMP: r.next_proto_class = CLS_ICMP;
                    PNUM_IPIP: r.next_proto_class = CLS_IPIP;
                    PNUM_IPV6: r.next_proto_class = CLS_IPV6;
                    PNUM_MPLS: r.next_proto_class = CLS_MPLS;
                    default:   r.next_proto_class = CLS_PAYLOAD;
                endcase
                opts = hl - 6'(FIXED_HEADER_BYTES);
                // options count only when the whole header was captured
                if (!(opts > 0 && cap >= hl)) opts = '0;
                r.options_length = opts;
                r.layer_size     = 16'(FIXED_HEADER_BYTES) + {10'd0, opts};
                r.trimmed_size   = (cap > tl) ? tl : cap;
            end else begin
                r.next_proto_class = CLS_NONE;
                r.options_length   = '0;
                r.layer_size       = cap;
                r.trimmed_size     = cap;
            end
            r.protocol_number = hdr_bytes[OFS_PROTO];
            r.source_address  = {hdr_bytes[OFS_SRC], hdr_bytes[OFS_SRC+1],
                                 hdr_bytes[OFS_SRC+2], hdr_bytes[OFS_SRC+3]};
            r.dest_address    = {hdr_bytes[OFS_DST], hdr_bytes[OFS_DST+1],
                                 hdr_bytes[OFS_DST+2], hdr_bytes[OFS_DST+3]};
            r.time_to_live    = hdr_bytes[OFS_TTL];
            return r;
        endfunction

        // Fold one accepted byte into the packet state
        function void note_byte(logic [7:0] b, logic last);
            int unsigned pos;
            pos = seen_count;
            if (pos < FIXED_HEADER_BYTES) begin
                hdr_bytes[pos] = b;
                if (pos != OFS_CSUM_HI && pos != OFS_CSUM_LO) begin
                    run_sum = run_sum + (pos[0] ? {9'd0, b} : {1'b0, b, 8'd0});
                    run_sum = {1'b0, run_sum[15:0]} + {16'd0, run_sum[16]};
                end
            end
            if (seen_count != COUNT_MAX) seen_count = seen_count + 16'd1;
            if (last) begin
                expected_summaries.push_back(summarize_packet());
                clear_packet();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Compare one delivered summary with the oldest expected one
        function void check_result(logic [M_DATA_W-1:0] data);
            t_result got;
            t_result want;
            got = t_result'(data[RESULT_W-1:0]);
            if (expected_summaries.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %0h", $time, data);
                return;
            end
            want = expected_summaries.pop_front();
            checked++;
            compare_field("pad bits", '0, 32'(data[M_DATA_W-1:RESULT_W]));
            compare_field("checksum_good", want.checksum_good, got.checksum_good);
            compare_field("lengths_valid", want.lengths_valid, got.lengths_valid);
            compare_field("next_proto_class", want.next_proto_class, got.next_proto_class);
            compare_field("header_bytes", want.header_bytes, got.header_bytes);
            compare_field("total_length", want.total_length, got.total_length);
            compare_field("options_length", want.options_length, got.options_length);
            compare_field("layer_size", want.layer_size, got.layer_size);
            compare_field("trimmed_size", want.trimmed_size, got.trimmed_size);
            compare_field("protocol_number", want.protocol_number, got.protocol_number);
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("dest_address", want.dest_address, got.dest_address);
            compare_field("time_to_live", want.time_to_live, got.time_to_live);
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata   = '0;   // [7:0] data_byte
    logic                i_s_tlast   = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    // [0] checksum_good, [1] lengths_valid, [4:2] next_proto_class,
    // [10:5] header_bytes, [26:11] total_length, [32:27] options_length,
    // [48:33] layer_size, [64:49] trimmed_size, [72:65] protocol_number,
    // [104:73] source_address, [136:105] dest_address, [144:137] time_to_live
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_wdata = 1'b0;

    header_scoreboard board = new();

    bit         calm = 1'b0;
    int         stall_left = 0;
    int         quiet = 0;
    int         packets_sent = 0;
    int         bytes_sent = 0;
    int         cfg_writes = 0;
    logic [7:0] hdr_work [FIXED_HEADER_BYTES];
    logic [7:0] pkt_bytes [$];

    ipv4_header_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Monitor both streams and the config port
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.set_csum_check(i_cfg_wdata);
            if (i_s_tvalid && o_s_tready) board.note_byte(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
        end
    end

    // Stall the result stream in random bursts
    always @(posedge i_clk) begin
        if (calm) begin
            i_m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] header_checksum();
        logic [16:0] acc;
        acc = '0;
        for (int i = 0; i < FIXED_HEADER_BYTES; i += 2) begin
            if (i != OFS_CSUM_HI) begin
                acc = acc + {1'b0, hdr_work[i], hdr_work[i+1]};
                acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
            end
        end
        return ~acc[15:0];
    endfunction

    // Mostly sane header with random content; lengths and checksum sometimes off
    function automatic void build_header_packet();
        int          ihl;
        int          hl;
        int          base;
        int          cap;
        int          tl;
        logic [15:0] csum;
        ihl = ($urandom_range(0, 9) < 7) ? $urandom_range(5, 7) : $urandom_range(8, 15);
        if ($urandom_range(0, 9) == 0) ihl = $urandom_range(0, 4);
        hl   = ihl * 4;
        base = (hl < FIXED_HEADER_BYTES) ? FIXED_HEADER_BYTES : hl;
        if ($urandom_range(0, 4) == 0)
            cap = $urandom_range(FIXED_HEADER_BYTES, base);
        else
            cap = base + $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: tl = cap;
            4, 5:       tl = cap - $urandom_range(1, 6);
            6, 7:       tl = cap + $urandom_range(1, 200);
            8:          tl = $urandom_range(0, hl);
            default:    tl = $urandom_range(0, 65535);
        endcase
        if (tl < 0) tl = 0;
        foreach (hdr_work[i]) hdr_work[i] = 8'($urandom);
        hdr_work[OFS_VER_IHL] = {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)};
        hdr_work[OFS_TLEN_HI] = tl[15:8];
        hdr_work[OFS_TLEN_LO] = tl[7:0];
        case ($urandom_range(0, 7))
            0:       hdr_work[OFS_PROTO] = PNUM_TCP;
            1:       hdr_work[OFS_PROTO] = PNUM_UDP;
            2:       hdr_work[OFS_PROTO] = PNUM_ICMP;
            3:       hdr_work[OFS_PROTO] = PNUM_IPIP;
            4:       hdr_work[OFS_PROTO] = PNUM_IPV6;
            5:       hdr_work[OFS_PROTO] = PNUM_MPLS;
            default: hdr_work[OFS_PROTO] = 8'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0) begin
            csum = header_checksum();
            hdr_work[OFS_CSUM_HI] = csum[15:8];
            hdr_work[OFS_CSUM_LO] = csum[7:0];
        end
        pkt_bytes.delete();
        for (int i = 0; i < cap; i++)
            pkt_bytes.push_back((i < FIXED_HEADER_BYTES) ? hdr_work[i] : 8'($urandom));
    endfunction

    function automatic void build_noise_packet(int len);
        pkt_bytes.delete();
        for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
    endfunction

    // Offer one byte, with an occasional gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        packets_sent++;
    endtask

    // Drain the block, let it settle, then write the enable
    task automatic write_csum_check(input logic on);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_csum_check(1'b1);

        // Directed: one-byte packet of all ones, short packet of zeros
        pkt_bytes = '{8'hFF};
        send_packet();
        pkt_bytes = '{8'h00, 8'h00, 8'h00};
        send_packet();

        // Directed: minimal TCP header, total length exactly 20, good checksum
        hdr_work = '{8'h45, 8'h00, 8'h00, 8'h14, 8'hBE, 8'hEF, 8'h40, 8'h00,
                     8'hFF, PNUM_TCP, 8'h00, 8'h00, 8'hC0, 8'hA8, 8'h00, 8'h01,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
        {hdr_work[OFS_CSUM_HI], hdr_work[OFS_CSUM_LO]} = header_checksum();
        pkt_bytes.delete();
        foreach (hdr_work[i]) pkt_bytes.push_back(hdr_work[i]);
        send_packet();

        // Random packets in phases; enable off first, then random, then on, then random again
        write_csum_check(1'b0);
        while (bytes_sent < RANDOM_BYTES || packets_sent < MIN_PACKETS) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  build_noise_packet($urandom_range(1, FIXED_HEADER_BYTES - 1));
                3:        build_noise_packet($urandom_range(20, 40));
                default:  build_header_packet();
            endcase
            bytes_sent += pkt_bytes.size();
            if (bytes_sent >= RANDOM_BYTES - 110) calm = 1'b1;
            send_packet();

            if (packets_sent % PHASE_PACKETS == 0)
                write_csum_check((packets_sent / PHASE_PACKETS == 2) ? 1'b1 : 1'($urandom));
        end

        // Wait for the tail of the results
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d packets (%0d random bytes after the directed ones),",
                 packets_sent, bytes_sent);
        $display("%0d summaries checked across %0d checksum-enable writes.",
                 board.checked, cfg_writes);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
